// ===== hw/rtl/crmi_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crmi_pkg
// Shared defaults and widths for the Catmull-Rom interpolator.
// -----------------------------------------------------------------------------
package crmi_pkg;

   // Default coordinate width, signed Q8.8
   localparam int COORD_WIDTH_DEF        = 16;
   // Default fraction bits of the curve position (2^F means 1.0)
   localparam int POSITION_FRAC_BITS_DEF = 16;
   // Headroom above F fraction bits for the signed spline weights
   localparam int WEIGHT_GUARD_BITS      = 5;

endpackage : crmi_pkg

// ===== hw/rtl/crmi_weight_gen.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// crmi_weight_gen
// Three-stage pipeline: s^2, s^3, then the four Catmull-Rom basis weights.
// -----------------------------------------------------------------------------
module crmi_weight_gen #(
   parameter int POSITION_FRAC_BITS = crmi_pkg::POSITION_FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     s_valid,
   input  logic [POSITION_FRAC_BITS:0]              s_value,
   output logic                                     w_valid,
   output logic signed [POSITION_FRAC_BITS+crmi_pkg::WEIGHT_GUARD_BITS-1:0] w_a,
   output logic signed [POSITION_FRAC_BITS+crmi_pkg::WEIGHT_GUARD_BITS-1:0] w_b,
   output logic signed [POSITION_FRAC_BITS+crmi_pkg::WEIGHT_GUARD_BITS-1:0] w_c,
   output logic signed [POSITION_FRAC_BITS+crmi_pkg::WEIGHT_GUARD_BITS-1:0] w_d
);
   import crmi_pkg::*;

   localparam int F  = POSITION_FRAC_BITS;
   localparam int PW = F + 1;
   localparam int WW = F + WEIGHT_GUARD_BITS;
   localparam logic [2*PW-1:0] HALF_LSB = (2*PW)'(1) << (F - 1);

   // stage A: s^2
   logic          va_ff;
   logic [PW-1:0] sa_ff;
   logic [PW-1:0] s2a_ff;
   logic [2*PW-1:0] sq_in;
   logic [PW-1:0] s2_in;

   // stage B: s^3
   logic          vb_ff;
   logic [PW-1:0] sb_ff;
   logic [PW-1:0] s2b_ff;
   logic [PW-1:0] s3b_ff;
   logic [2*PW-1:0] cube_in;
   logic [PW-1:0] s3_in;

   // stage C: weights
   logic          vc_ff;
   logic signed [WW-1:0] s_x, s2_x, s3_x, two_x;
   logic signed [WW-1:0] wa_in, wb_in, wc_in, wd_in;
   logic signed [WW-1:0] wa_ff, wb_ff, wc_ff, wd_ff;

   assign sq_in   = (2*PW)'(s_value) * (2*PW)'(s_value) + HALF_LSB;
   assign s2_in   = sq_in[F+PW-1:F];
   assign cube_in = (2*PW)'(s2a_ff) * (2*PW)'(sa_ff) + HALF_LSB;
   assign s3_in   = cube_in[F+PW-1:F];

   assign s_x   = WW'(sb_ff);
   assign s2_x  = WW'(s2b_ff);
   assign s3_x  = WW'(s3b_ff);
   assign two_x = WW'(1) << (F + 1);

   assign wa_in = (s2_x <<< 1) - s3_x - s_x;
   assign wb_in = (s3_x <<< 1) + s3_x - (s2_x <<< 2) - s2_x + two_x;
   assign wc_in = (s2_x <<< 2) + s_x - (s3_x <<< 1) - s3_x;
   assign wd_in = s3_x - s2_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= s_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff  <= s_value;
      s2a_ff <= s2_in;
      sb_ff  <= sa_ff;
      s2b_ff <= s2a_ff;
      s3b_ff <= s3_in;
      wa_ff  <= wa_in;
      wb_ff  <= wb_in;
      wc_ff  <= wc_in;
      wd_ff  <= wd_in;
   end

   assign w_valid = vc_ff;
   assign w_a     = wa_ff;
   assign w_b     = wb_ff;
   assign w_c     = wc_ff;
   assign w_d     = wd_ff;

`ifndef ASSERT_OFF
   // the four basis weights always sum to exactly two
   a_weight_sum : assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> ((WW+2)'(wa_ff) + (WW+2)'(wb_ff) + (WW+2)'(wc_ff) + (WW+2)'(wd_ff)
                 == ((WW+2)'(1) << (F + 1))))
      else $error("crmi_weight_gen: weights do not sum to two");

   // s^2 never exceeds one for a clamped position
   a_square_range : assert property (@(posedge clock) disable iff (reset)
      va_ff |-> (s2a_ff <= (PW'(1) << F)))
      else $error("crmi_weight_gen: s^2 above one");

   // weight valid trails the incoming position by three stages
   a_valid_delay : assert property (@(posedge clock) disable iff (reset)
      vc_ff == $past(s_valid, 3))
      else $error("crmi_weight_gen: valid pipeline out of step");
`endif

endmodule : crmi_weight_gen

// ===== hw/rtl/catmull_rom_interpolator.sv =====
`timescale 1ns / 1ps
// Pipeline: a request accepted at a clock edge passes 7 register stages from port
//   to port: inputs, s^2, s^3, weights, products, sum and the output register.
// Throughput: one request per clock, sustained, while busy is low.
// Reset: synchronous, active high; clears every stage valid. busy is registered:
//   high in reset and the cycle after it. The receiver cannot stall results.
// -----------------------------------------------------------------------------
// catmull_rom_interpolator
// Uniform Catmull-Rom spline evaluation of one coordinate per request,
// fixed point, rounded to nearest and saturated to the coordinate width.
// -----------------------------------------------------------------------------
module catmull_rom_interpolator #(
   parameter int COORD_WIDTH        = crmi_pkg::COORD_WIDTH_DEF,
   parameter int POSITION_FRAC_BITS = crmi_pkg::POSITION_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  logic signed [COORD_WIDTH-1:0]   req_point_before,
   input  logic signed [COORD_WIDTH-1:0]   req_segment_start,
   input  logic signed [COORD_WIDTH-1:0]   req_segment_end,
   input  logic signed [COORD_WIDTH-1:0]   req_point_after,
   input  logic [POSITION_FRAC_BITS:0]     req_position,
   // result channel
   output logic                            rsp_valid,
   output logic signed [COORD_WIDTH-1:0]   rsp_curve_value,
   output logic                            rsp_saturated
);
   import crmi_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int F     = POSITION_FRAC_BITS;
   localparam int PW    = F + 1;
   localparam int WW    = F + WEIGHT_GUARD_BITS;
   localparam int PRODW = WW + W;
   localparam int ACCW  = PRODW + 2;
   // stages the control values wait while the weights are formed
   localparam int PDLY  = 3;

   localparam logic [PW-1:0] POS_ONE = PW'(1) << F;
   localparam logic signed [ACCW-1:0] Q_MAX = {{(ACCW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [ACCW-1:0] Q_MIN = {{(ACCW-W+1){1'b1}}, {(W-1){1'b0}}};

   // --------------------------------------------------------------------------
   // Request capture. The pipeline never stalls; busy is only reset, registered.
   // --------------------------------------------------------------------------
   logic req_accept;
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy       = busy_ff;
   assign req_accept = start && !busy_ff;

   // stage 1: registered inputs, position clamped to one
   logic                v1_ff;
   logic [PW-1:0]       s1_in;
   logic [PW-1:0]       s1_ff;
   logic signed [W-1:0] p0_ff [PDLY+1];
   logic signed [W-1:0] p1_ff [PDLY+1];
   logic signed [W-1:0] p2_ff [PDLY+1];
   logic signed [W-1:0] p3_ff [PDLY+1];

   assign s1_in = (req_position > POS_ONE) ? POS_ONE : req_position;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_accept;
      end
   end

   // control values ride a short shift line alongside the weight pipeline
   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      p0_ff[0] <= req_point_before;
      p1_ff[0] <= req_segment_start;
      p2_ff[0] <= req_segment_end;
      p3_ff[0] <= req_point_after;
      for (int i = 1; i <= PDLY; i++) begin
         p0_ff[i] <= p0_ff[i-1];
         p1_ff[i] <= p1_ff[i-1];
         p2_ff[i] <= p2_ff[i-1];
         p3_ff[i] <= p3_ff[i-1];
      end
   end

   // --------------------------------------------------------------------------
   // Stages 2..4: s^2, s^3 and basis weights (each a rounded Q.F value)
   // --------------------------------------------------------------------------
   logic                 w_valid;
   logic signed [WW-1:0] w_a, w_b, w_c, w_d;

   crmi_weight_gen #(
      .POSITION_FRAC_BITS (F)
   ) u_weight_gen (
      .clock   (clock),
      .reset   (reset),
      .s_valid (v1_ff),
      .s_value (s1_ff),
      .w_valid (w_valid),
      .w_a     (w_a),
      .w_b     (w_b),
      .w_c     (w_c),
      .w_d     (w_d)
   );

   // --------------------------------------------------------------------------
   // Stage 5: four weight x coordinate products, one multiplier each
   // --------------------------------------------------------------------------
   logic                    v5_ff;
   logic signed [PRODW-1:0] m0_in, m1_in, m2_in, m3_in;
   logic signed [PRODW-1:0] m0_ff, m1_ff, m2_ff, m3_ff;

   assign m0_in = w_a * p0_ff[PDLY];
   assign m1_in = w_b * p1_ff[PDLY];
   assign m2_in = w_c * p2_ff[PDLY];
   assign m3_in = w_d * p3_ff[PDLY];

   // --------------------------------------------------------------------------
   // Stage 6: sum plus the rounding half (2^F ahead of the /2^(F+1))
   // --------------------------------------------------------------------------
   logic                   v6_ff;
   logic signed [ACCW-1:0] acc_in;
   logic signed [ACCW-1:0] acc_ff;

   assign acc_in = ACCW'(m0_ff) + ACCW'(m1_ff) + ACCW'(m2_ff) + ACCW'(m3_ff)
                   + (ACCW'(1) << F);

   // --------------------------------------------------------------------------
   // Stage 7: floor shift, saturation, output register
   // --------------------------------------------------------------------------
   logic                   q_hi, q_lo;
   logic signed [ACCW-1:0] q_full;
   logic                   v7_ff;
   logic signed [W-1:0]    val_in;
   logic signed [W-1:0]    val_ff;
   logic                   sat_in;
   logic                   sat_ff;

   // arithmetic shift floors toward minus infinity
   assign q_full = acc_ff >>> (F + 1);
   assign q_hi   = q_full > Q_MAX;
   assign q_lo   = q_full < Q_MIN;

   always_comb begin
      priority if (q_hi) begin
         val_in = Q_MAX[W-1:0];
         sat_in = 1'b1;
      end else if (q_lo) begin
         val_in = Q_MIN[W-1:0];
         sat_in = 1'b1;
      end else begin
         val_in = q_full[W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v5_ff <= w_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      m0_ff  <= m0_in;
      m1_ff  <= m1_in;
      m2_ff  <= m2_in;
      m3_ff  <= m3_in;
      acc_ff <= acc_in;
      val_ff <= val_in;
      sat_ff <= sat_in;
   end

   assign rsp_valid       = v7_ff;
   assign rsp_curve_value = val_ff;
   assign rsp_saturated   = sat_ff;

`ifndef ASSERT_OFF
   // every accepted request comes out as a result strobe through the valid pipeline
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid == $past(req_accept, 7))
      else $error("catmull_rom_interpolator: result strobe out of step");

   // a clipped result sits at one of the two limits
   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_curve_value == Q_MAX[W-1:0] || rsp_curve_value == Q_MIN[W-1:0]))
      else $error("catmull_rom_interpolator: saturated value not at a limit");

   // once busy has fallen after reset the block takes a request every cycle
   a_never_busy : assert property (@(posedge clock)
      (!reset && !$past(reset)) |-> !busy)
      else $error("catmull_rom_interpolator: busy outside reset");
`endif

endmodule : catmull_rom_interpolator
